// ===== rtl/pcmd_pkg.sv =====
`timescale 1ns / 1ps

package pcmd_pkg;

    localparam int CFG_W   = 7;
    localparam int WORD_W  = 32;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_DEPTH  = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    localparam logic [1:0] DEPTH_8  = 2'd0;
    localparam logic [1:0] DEPTH_16 = 2'd1;
    localparam logic [1:0] DEPTH_24 = 2'd2;
    localparam logic [1:0] DEPTH_32 = 2'd3;

    // biased exponent that makes the integer magnitude read as value * 2^(bits-1)
    localparam logic signed [9:0] EXP_8  = 10'sd151;
    localparam logic signed [9:0] EXP_16 = 10'sd143;
    localparam logic signed [9:0] EXP_24 = 10'sd135;
    localparam logic signed [9:0] EXP_32 = 10'sd127;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_ADD,
        ST_PRE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_CONV,
        PH_ADD,
        PH_DIV
    } phase_t;

endpackage

// ===== rtl/pcmd_in_if.sv =====
`timescale 1ns / 1ps

interface pcmd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

// ===== rtl/pcmd_out_if.sv =====
`timescale 1ns / 1ps

interface pcmd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] mono_sample;
    logic        bad_sample;

    modport source (output valid, output mono_sample, output bad_sample, input ready);
    modport sink   (input valid, input mono_sample, input bad_sample, output ready);
endinterface

// ===== rtl/pcm_sample_decode_downmix.sv =====
// Sequence: a float sample that does not close a frame is added to the running sum
// and normalized, with extra steps after cancellation; an integer sample is first
// converted in the normalizer. A frame's last sample then pre-normalizes the sum,
// divides it by the channel count (radix-2, one quotient bit per step), normalizes, emits.
// Throughput: one transaction at a time; ready only while idle.
// Reset (rst_n, async low): registers to integer/16-bit/1 channel, frame state cleared.
`timescale 1ns / 1ps

module pcm_sample_decode_downmix #(
    parameter int MAX_CHANNELS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [1:0]                   wr_index,
    input  logic [pcmd_pkg::CFG_W-1:0]   wr_data,
    pcmd_in_if.sink                      samples,
    pcmd_out_if.source                   mono
);
    import pcmd_pkg::*;

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic               fmt_reg;
    logic [1:0]         depth_reg;
    logic [CFG_W-1:0]   count_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        sum_reg, sum_next;
    logic               err_reg, err_next;
    logic [31:0]        smp_reg, smp_next;
    logic [CFG_W-1:0]   cnt_reg, cnt_next;
    logic               last_reg, last_next;

    logic [32:0]        nm_reg, nm_next;
    logic signed [9:0]  ne_reg, ne_next;
    logic               ns_reg, ns_next;

    logic [23:0]        dsig_reg, dsig_next;
    logic signed [9:0]  de_reg, de_next;
    logic [30:0]        dd_reg, dd_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [4:0]         dcnt_reg, dcnt_next;

    logic [31:0]        res_reg, res_next;
    logic               ovalid_reg, ovalid_next;
    logic [31:0]        omono_reg, omono_next;
    logic               obad_reg, obad_next;

    // input decode
    logic [CFG_W-1:0]   cnt_eff;
    logic               accept;
    logic               is_last;
    logic [31:0]        w;
    logic [31:0]        ival;
    logic               ineg;
    logic [31:0]        imag;
    logic signed [9:0]  iexp;

    // normalizer / packer
    logic [32:0]        rsh;
    logic               inc;
    logic [24:0]        mr;
    logic signed [9:0]  fe;
    logic [31:0]        packed_res;
    logic               norm_done;

    // adder
    logic [7:0]         ea, eb, eea, eeb, ex, ey, dexp;
    logic [23:0]        siga, sigb;
    logic               a_big, sx;
    logic [32:0]        xf, yf, ys;
    logic               lost;
    logic [32:0]        asum;

    // divider step
    logic [CFG_W:0]     dt;
    logic               qbit;
    logic [CFG_W-1:0]   drem;

    assign accept = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE);
    assign mono.valid = ovalid_reg;
    assign mono.mono_sample = omono_reg;
    assign mono.bad_sample = obad_reg;

    always_comb
    begin
        if (count_reg == '0)
            cnt_eff = CFG_W'(1);
        else if (count_reg > CFG_W'(MAX_CHANNELS))
            cnt_eff = CFG_W'(MAX_CHANNELS);
        else
            cnt_eff = count_reg;
        is_last = (CFG_W'(pos_reg) + CFG_W'(1)) >= cnt_eff;

        w = samples.sample_word;
        unique case (depth_reg)
            DEPTH_8:
            begin
                ival = {24'd0, w[7:0]} - 32'd128;
                iexp = EXP_8;
            end
            DEPTH_16:
            begin
                ival = {{16{w[15]}}, w[15:0]};
                iexp = EXP_16;
            end
            DEPTH_24:
            begin
                ival = {{8{w[23]}}, w[23:0]};
                iexp = EXP_24;
            end
            default:
            begin
                ival = w;
                iexp = EXP_32;
            end
        endcase
        ineg = ival[31];
        imag = ineg ? (32'd0 - ival) : ival;
    end

    always_comb
    begin
        rsh = {1'b0, nm_reg[32:2], nm_reg[1] | nm_reg[0]};
        inc = nm_reg[7] & ((|nm_reg[6:0]) | nm_reg[8]);
        mr = {1'b0, nm_reg[31:8]} + {24'd0, inc};
        if (mr[24])
            fe = ne_reg + 10'sd1;
        else if (mr[23])
            fe = ne_reg;
        else
            fe = 10'sd0;
        if (nm_reg == '0)
            packed_res = {ns_reg, 31'd0};
        else if (fe >= 10'sd255)
            packed_res = {ns_reg, 8'hFF, 23'd0};
        else
            packed_res = {ns_reg, fe[7:0], mr[24] ? 23'd0 : mr[22:0]};
        norm_done = !nm_reg[32] && !(ne_reg < 10'sd1)
                    && (nm_reg[31] || !(ne_reg > 10'sd1) || nm_reg == '0);
    end

    always_comb
    begin
        ea = sum_reg[30:23];
        eb = smp_reg[30:23];
        eea = (ea == 8'd0) ? 8'd1 : ea;
        eeb = (eb == 8'd0) ? 8'd1 : eb;
        siga = {ea != 8'd0, sum_reg[22:0]};
        sigb = {eb != 8'd0, smp_reg[22:0]};
        a_big = sum_reg[30:0] >= smp_reg[30:0];
        ex = a_big ? eea : eeb;
        ey = a_big ? eeb : eea;
        sx = a_big ? sum_reg[31] : smp_reg[31];
        xf = {1'b0, (a_big ? siga : sigb), 8'd0};
        yf = {1'b0, (a_big ? sigb : siga), 8'd0};
        dexp = ex - ey;
        lost = (yf & ~({33{1'b1}} << dexp)) != '0;
        ys = (yf >> dexp) | {32'd0, lost};
        if (sum_reg[31] == smp_reg[31])
            asum = xf + ys;
        else
            asum = xf - ys;
    end

    always_comb
    begin
        dt = {rem_reg, dd_reg[30]};
        qbit = dt >= {1'b0, cnt_reg};
        drem = qbit ? CFG_W'(dt - {1'b0, cnt_reg}) : dt[CFG_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pos_next = pos_reg;
        sum_next = sum_reg;
        err_next = err_reg;
        smp_next = smp_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        nm_next = nm_reg;
        ne_next = ne_reg;
        ns_next = ns_reg;
        dsig_next = dsig_reg;
        de_next = de_reg;
        dd_next = dd_reg;
        rem_next = rem_reg;
        dcnt_next = dcnt_reg;
        res_next = res_reg;
        omono_next = omono_reg;
        obad_next = obad_reg;
        ovalid_next = ovalid_reg && !mono.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = cnt_eff;
                    last_next = is_last;
                    if (!is_last)
                        pos_next = pos_reg + POS_W'(1);
                    if (fmt_reg)
                    begin
                        if (w[30:23] == 8'hFF)
                        begin
                            smp_next = 32'd0;
                            err_next = 1'b1;
                        end
                        else
                            smp_next = w;
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        nm_next = {1'b0, imag};
                        ne_next = iexp;
                        ns_next = ineg;
                        phase_next = PH_CONV;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_ADD:
            begin
                if (ea == 8'hFF)
                begin
                    if (last_reg)
                    begin
                        res_next = sum_reg;
                        state_next = ST_EMIT;
                    end
                    else
                        state_next = ST_IDLE;
                end
                else
                begin
                    nm_next = asum;
                    ne_next = {2'b00, ex};
                    ns_next = (asum == '0) ? (sum_reg[31] & smp_reg[31]) : sx;
                    phase_next = PH_ADD;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (nm_reg[32] || ne_reg < 10'sd1)
                begin
                    nm_next = rsh;
                    ne_next = ne_reg + 10'sd1;
                end
                else if (!norm_done)
                begin
                    nm_next = {nm_reg[31:0], 1'b0};
                    ne_next = ne_reg - 10'sd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_CONV:
                        begin
                            smp_next = packed_res;
                            state_next = ST_ADD;
                        end
                        PH_ADD:
                        begin
                            sum_next = packed_res;
                            if (!last_reg)
                                state_next = ST_IDLE;
                            else if (packed_res[30:23] == 8'hFF || packed_res[30:0] == '0)
                            begin
                                res_next = packed_res;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                dsig_next = {packed_res[30:23] != 8'd0, packed_res[22:0]};
                                de_next = (packed_res[30:23] == 8'd0)
                                          ? 10'sd1 : {2'b00, packed_res[30:23]};
                                state_next = ST_PRE;
                            end
                        end
                        default:
                        begin
                            res_next = packed_res;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PRE:
            begin
                if (!dsig_reg[23])
                begin
                    dsig_next = {dsig_reg[22:0], 1'b0};
                    de_next = de_reg - 10'sd1;
                end
                else
                begin
                    dd_next = {dsig_reg, 7'd0};
                    rem_next = '0;
                    dcnt_next = 5'd30;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dd_next = {dd_reg[29:0], qbit};
                rem_next = drem;
                dcnt_next = dcnt_reg - 5'd1;
                if (dcnt_reg == 5'd0)
                begin
                    nm_next = {1'b0, dd_reg[29:0], qbit, drem != '0};
                    ne_next = de_reg;
                    ns_next = sum_reg[31];
                    phase_next = PH_DIV;
                    state_next = ST_NORM;
                end
            end
            ST_EMIT:
            begin
                if (!ovalid_reg || mono.ready)
                begin
                    ovalid_next = 1'b1;
                    omono_next = res_reg;
                    obad_next = err_reg;
                    err_next = 1'b0;
                    sum_next = 32'd0;
                    pos_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_CONV;
            fmt_reg    <= 1'b0;
            depth_reg  <= DEPTH_16;
            count_reg  <= CFG_W'(1);
            pos_reg    <= '0;
            sum_reg    <= 32'd0;
            err_reg    <= 1'b0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_FORMAT: fmt_reg <= wr_data[0];
                    REG_DEPTH:  depth_reg <= wr_data[1:0];
                    REG_COUNT:  count_reg <= wr_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        cnt_reg   <= cnt_next;
        nm_reg    <= nm_next;
        ne_reg    <= ne_next;
        ns_reg    <= ns_next;
        dsig_reg  <= dsig_next;
        de_reg    <= de_next;
        dd_reg    <= dd_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        res_reg   <= res_next;
        omono_reg <= omono_next;
        obad_reg  <= obad_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("ready while a transaction is in progress");

    a_emit_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!ovalid_reg || mono.ready))
        |=> mono.valid && pos_reg == '0 && !err_reg)
        else $error("frame state not cleared on result");

    a_div_no_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NORM && phase_reg == PH_DIV) |-> !nm_reg[32])
        else $error("quotient overflow in normalizer");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pcmd_pkg::*;

    typedef struct packed {
        logic [31:0] mono_sample;
        logic        bad_sample;
    } frame_avg_t;

    localparam int DRAIN_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n;
    logic wr_en;
    logic [1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    pcmd_in_if  in_ch();
    pcmd_out_if out_ch();

    pcm_sample_decode_downmix dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .samples  (in_ch.sink),
        .mono     (out_ch.source)
    );

    // local copy of the block's registers and frame state
    logic        fmt_float;
    logic [1:0]  depth_sel;
    logic [6:0]  chan_cnt;
    int          chan_pos;
    logic [31:0] sum_bits;
    logic        sum_err;

    logic [31:0] pending_words[$];
    frame_avg_t  expected_avgs[$];
    int          words_queued;
    int          words_taken;
    int          in_gap;
    int          out_gap;
    bit          no_idle;
    bit          hold_in;
    int          errors;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // double value to binary32 pattern, nearest even
    function automatic logic [31:0] to_single(real x);
        logic [63:0] d;
        logic [53:0] sig;
        logic [53:0] keep;
        logic [53:0] rem;
        logic [53:0] half;
        logic [31:0] b;
        int fe;
        int sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF)
            return {d[63], 8'hFF, 23'h0};
        if (d[62:52] == 11'h000)
            return {d[63], 31'h0};
        fe = int'(d[62:52]) - 1023 + 127;
        if (fe >= 255)
            return {d[63], 8'hFF, 23'h0};
        sig = {2'b01, d[51:0]};
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 54)
            return {d[63], 31'h0};
        keep = sig >> sh;
        rem = sig & ((54'd1 << sh) - 54'd1);
        half = 54'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0]))
            keep = keep + 54'd1;
        if (fe >= 1)
            b = (32'(fe - 1) << 23) + 32'(keep);
        else
            b = 32'(keep);
        if (b >= 32'h7F80_0000)
            b = 32'h7F80_0000;
        return {d[63], b[30:0]};
    endfunction

    function automatic real to_double(logic [31:0] f);
        if (f[30:0] == 31'h0)
            return $bitstoreal({f[31], 63'h0});
        if (f[30:23] == 8'hFF)
            return $bitstoreal({f[31], 11'h7FF, 52'h0});
        if (f[30:23] == 8'h00)
            return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        return $bitstoreal({f[31], 11'(int'(f[30:23]) + 896), f[22:0], 29'h0});
    endfunction

    function automatic logic [31:0] word_value(logic [31:0] w, output logic bad);
        real v;
        bad = 1'b0;
        if (fmt_float)
        begin
            if (w[30:23] == 8'hFF)
            begin
                bad = 1'b1;
                return 32'h0;
            end
            return w;
        end
        case (depth_sel)
            DEPTH_8:  v = (real'(w[7:0]) - 128.0) / 128.0;
            DEPTH_16: v = real'($signed(w[15:0])) / 32768.0;
            DEPTH_24: v = real'($signed(w[23:0])) / 8388608.0;
            default:  v = real'($signed(w)) / 2147483648.0;
        endcase
        return to_single(v);
    endfunction

    function automatic void accumulate_sample(logic [31:0] w);
        logic [31:0] s;
        logic bad;
        int cnt;
        frame_avg_t r;
        cnt = (chan_cnt == 0) ? 1 : (chan_cnt > 64) ? 64 : int'(chan_cnt);
        s = word_value(w, bad);
        if (bad)
            sum_err = 1'b1;
        sum_bits = to_single(to_double(sum_bits) + to_double(s));
        if (chan_pos + 1 >= cnt)
        begin
            r.mono_sample = to_single(to_double(sum_bits) / real'(cnt));
            r.bad_sample = sum_err;
            expected_avgs.push_back(r);
            chan_pos = 0;
            sum_bits = 32'h0;
            sum_err = 1'b0;
        end
        else
            chan_pos = chan_pos + 1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.sample_word <= 32'h0;
            in_gap = 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                accumulate_sample(in_ch.sample_word);
                words_taken++;
            end
            nv = 1'b0;
            if (in_gap > 0)
                in_gap--;
            else if (pending_words.size() > 0 && !hold_in)
            begin
                in_ch.sample_word <= pending_words.pop_front();
                nv = 1'b1;
                in_gap = pick_gap();
            end
            in_ch.valid <= nv;
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        frame_avg_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_avgs.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: mono=%h bad=%b",
                                 out_ch.mono_sample, out_ch.bad_sample);
                end
                else
                begin
                    e = expected_avgs.pop_front();
                    if (e.mono_sample !== out_ch.mono_sample
                        || e.bad_sample !== out_ch.bad_sample)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp mono=%h bad=%b, got mono=%h bad=%b",
                                     e.mono_sample, e.bad_sample,
                                     out_ch.mono_sample, out_ch.bad_sample);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                out_gap = pick_gap();
            end
        end
    end

    task automatic wait_drained();
        while (words_taken != words_queued || expected_avgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        case (idx)
            REG_FORMAT: fmt_float = val[0];
            REG_DEPTH:  depth_sel = val[1:0];
            default:    chan_cnt = val[6:0];
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic queue_word(logic [31:0] w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [31:0] random_word();
        int r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 5)
            w = 32'h0;
        else if (r < 10)
            w = 32'hFFFF_FFFF;
        else if (r < 15)
            w = {1'b0, {31{1'b1}}};
        else if (r < 20)
            w = 32'h8000_0000;
        else if (fmt_float && r < 70)
            w[30:23] = 8'($urandom_range(110, 140));
        else if (fmt_float && r < 75)
            w[30:23] = 8'h00;
        return w;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] cnt_pick;
        int n;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_FORMAT;
        wr_data = '0;
        fmt_float = 1'b0;
        depth_sel = DEPTH_16;
        chan_cnt = 7'd1;
        chan_pos = 0;
        sum_bits = 32'h0;
        sum_err = 1'b0;
        words_queued = 0;
        words_taken = 0;
        no_idle = 1'b0;
        hold_in = 1'b0;
        errors = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 16-bit, one channel
        queue_word(32'h0000_0000);
        queue_word(32'hABCD_7FFF);
        queue_word(32'h0000_8000);
        queue_word(32'hFFFF_FFFF);
        wait_drained();

        write_reg(REG_DEPTH, CFG_W'(DEPTH_8));
        write_reg(REG_COUNT, 7'd0);
        end_writes();
        queue_word(32'h0000_0000);
        queue_word(32'hFFFF_FF80);
        queue_word(32'h0000_00FF);
        wait_drained();

        write_reg(REG_DEPTH, CFG_W'(DEPTH_24));
        write_reg(REG_COUNT, 7'd3);
        end_writes();
        queue_word(32'h0080_0000);
        queue_word(32'hFF7F_FFFF);
        queue_word(32'h0000_0001);
        queue_word(32'h0012_3456);
        wait_drained();

        // count drops mid-frame
        write_reg(REG_COUNT, 7'd1);
        write_reg(REG_DEPTH, CFG_W'(DEPTH_32));
        end_writes();
        queue_word(32'h7FFF_FFFF);
        queue_word(32'h8000_0000);
        queue_word(32'h0123_4567);
        wait_drained();

        write_reg(REG_FORMAT, 7'd1);
        write_reg(REG_DEPTH, CFG_W'(DEPTH_8));
        write_reg(REG_COUNT, 7'd2);
        end_writes();
        queue_word(32'h7F80_0000);
        queue_word(32'h3F80_0000);
        queue_word(32'hFFC0_0001);
        queue_word(32'h8000_0000);
        queue_word(32'h7F7F_FFFF);
        queue_word(32'h7F7F_FFFF);
        queue_word(32'h0000_0001);
        queue_word(32'h8000_0000);
        wait_drained();

        write_reg(REG_COUNT, 7'd127);
        end_writes();
        for (int i = 0; i < 64; i++)
            queue_word(random_word());
        wait_drained();

        // random phases, frames may straddle register changes
        for (int ph = 0; ph < 40; ph++)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            write_reg(REG_FORMAT, 7'($urandom_range(0, 1)));
            write_reg(REG_DEPTH, 7'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0: cnt_pick = 7'd0;
                1: cnt_pick = 7'd64;
                2: cnt_pick = 7'($urandom_range(65, 127));
                3, 4: cnt_pick = 7'($urandom_range(5, 63));
                default: cnt_pick = 7'($urandom_range(1, 4));
            endcase
            write_reg(REG_COUNT, cnt_pick);
            end_writes();
            n = $urandom_range(10, 36);
            for (int i = 0; i < n; i++)
                queue_word(random_word());
            if (ph == 20)
            begin
                hold_in = 1'b1;
                while (expected_avgs.size() != 0 || words_taken != words_queued - n)
                    @(posedge clk);
                repeat (40) @(posedge clk);
                hold_in = 1'b0;
            end
            wait_drained();
        end
        no_idle = 1'b0;

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
